// ===== design/prdp_pkg.sv =====
package prdp_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_X,
        S_DIV_Y,
        S_MUL_P,
        S_MUL_Q,
        S_MUL_PP,
        S_MUL_QQ,
        S_MUL_T,
        S_MUL_UX,
        S_MUL_UY,
        S_DIV_IX,
        S_DIV_IY,
        S_CHECK,
        S_PIX_X,
        S_PIX_Y,
        S_OUT
    } t_state;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_arith_op;

    typedef struct packed {
        logic         start;
        t_arith_op    op;
        logic [127:0] a;
        logic [127:0] b;
    } t_arith_req;

    typedef struct packed {
        logic         done;
        logic [191:0] prod;
        logic [127:0] quot;
    } t_arith_rsp;

    typedef struct packed {
        logic        sat;
        logic [47:0] val;
    } t_sat48;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO_Z  = 2'd1;
    localparam logic [1:0] ST_NO_CONV = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    localparam logic REQ_TO_RAY   = 1'b0;
    localparam logic REQ_TO_PIXEL = 1'b1;

    localparam logic [1:0] CFG_FOCAL  = 2'd0;
    localparam logic [1:0] CFG_PRIN_X = 2'd1;
    localparam logic [1:0] CFG_PRIN_Y = 2'd2;
    localparam logic [1:0] CFG_RADIAL = 2'd3;

    localparam logic [47:0] FOCAL_RESET = 48'h0001_0000_0000;

    // clip a sign and magnitude to the signed 48 bit range
    function automatic t_sat48 sat48(input logic neg, input logic [127:0] mag);
        t_sat48      r;
        logic [47:0] lim;
        logic [47:0] v;
        lim   = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        r.sat = (mag > {80'd0, lim});
        v     = r.sat ? lim : mag[47:0];
        r.val = neg ? (48'd0 - v) : v;
        return r;
    endfunction

endpackage

// ===== design/pinhole_radial_distortion_projection.sv =====
// Pinhole camera with one radial distortion term, all coordinates signed Q16.32.
// One request at a time: o_in_stall stays high from a transfer until its result
// is taken. All arithmetic runs on one bit-serial unit: a divide works through all
// 128 quotient bits, a multiply stops once none of its 64 multiplier bits is left set.
// A request without distortion costs two divides (plus two multiplies for a
// ray-to-pixel). With distortion a pixel-to-ray adds seven multiplies; a
// ray-to-pixel adds, per fixed-point iteration, five multiplies and two divides,
// for at most MAX_ITERATIONS iterations.
module pinhole_radial_distortion_projection
    import prdp_pkg::*;
#(
    parameter int MAX_ITERATIONS = 100
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic signed [47:0] i_in_x,
    input  logic signed [47:0] i_in_y,
    input  logic signed [47:0] i_in_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [47:0] o_out_x,
    output logic signed [47:0] o_out_y,
    output logic [1:0]         o_status
);

    localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(MAX_ITERATIONS - 1);

    function automatic logic [47:0] mag48(input logic [47:0] v);
        return v[47] ? (48'd0 - v) : v;
    endfunction

    t_state             r_state;
    t_state             n_state;
    logic               r_launched;
    logic [47:0]        r_focal;
    logic signed [47:0] r_ppx;
    logic signed [47:0] r_ppy;
    logic [63:0]        r_coeff;
    logic               r_req_type;
    logic [48:0]        r_nx;
    logic [48:0]        r_ny;
    logic               r_xneg;
    logic               r_yneg;
    logic [47:0]        r_den;
    logic [47:0]        r_ux;
    logic [47:0]        r_uy;
    logic [47:0]        r_rx;
    logic [47:0]        r_ry;
    logic [47:0]        r_qx;
    logic [47:0]        r_qy;
    logic [62:0]        r_fx;
    logic [62:0]        r_fy;
    logic [127:0]       r_sum;
    logic [127:0]       r_fac;
    logic               r_fneg;
    logic               r_sat;
    logic               r_conv;
    logic               r_zero;
    logic [ITER_W-1:0]  r_iter;

    t_arith_req arith_req;
    t_arith_rsp arith_rsp;

    logic         in_xfer;
    logic         k_neg;
    logic [63:0]  k_mag;
    logic         k_on;
    logic         op_state;
    logic         match;
    logic [48:0]  dx;
    logic [48:0]  dy;

    logic         q_neg;
    t_sat48       q_res;
    logic         m_neg;
    t_sat48       m_res;
    logic [127:0] t_val;
    logic [128:0] fac_sum;
    logic [127:0] fac_val;
    logic         fac_neg;
    logic [47:0]  pix_d;
    logic [47:0]  pix_pp;
    logic [95:0]  pix_m;
    logic [60:0]  pix_c;
    logic [63:0]  pix_sc;
    logic [63:0]  pix_s;
    logic [63:0]  pix_smag;
    t_sat48       pix_res;

    localparam logic [127:0] ONE_Q64 = {64'd1, 64'd0};

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign k_neg    = r_coeff[63];
    assign k_mag    = k_neg ? (64'd0 - r_coeff) : r_coeff;
    assign k_on     = (r_coeff != '0);
    assign op_state = (r_state != S_IDLE) && (r_state != S_CHECK) && (r_state != S_OUT);
    assign match    = (r_qx == r_rx) && (r_qy == r_ry);
    assign dx = {i_in_x[47], i_in_x} - {r_ppx[47], r_ppx};
    assign dy = {i_in_y[47], i_in_y} - {r_ppy[47], r_ppy};

    prdp_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (arith_req),
        .o_rsp   (arith_rsp)
    );

    // result shaping of the shared unit
    always_comb begin
        case (r_state)
            S_DIV_Y:  q_neg = r_yneg;
            S_DIV_IX: q_neg = r_ux[47] ^ r_fneg;
            S_DIV_IY: q_neg = r_uy[47] ^ r_fneg;
            default:  q_neg = r_xneg;
        endcase
        q_res = sat48(q_neg, arith_rsp.quot);

        m_neg = (r_state == S_MUL_UY) ? (r_ry[47] ^ r_fneg) : (r_rx[47] ^ r_fneg);
        m_res = sat48(m_neg, arith_rsp.prod[191:64]);

        t_val   = (arith_rsp.prod[191:184] != '0) ? '1 : arith_rsp.prod[183:56];
        fac_sum = {1'b0, ONE_Q64} + {1'b0, t_val};
        if (!k_neg) begin
            fac_val = fac_sum[128] ? '1 : fac_sum[127:0];
            fac_neg = 1'b0;
        end else if (ONE_Q64 >= t_val) begin
            fac_val = ONE_Q64 - t_val;
            fac_neg = 1'b0;
        end else begin
            fac_val = t_val - ONE_Q64;
            fac_neg = 1'b1;
        end

        pix_d    = (r_state == S_PIX_Y) ? r_ry : r_rx;
        pix_pp   = (r_state == S_PIX_Y) ? r_ppy : r_ppx;
        pix_m    = arith_rsp.prod[127:32];
        pix_c    = (pix_m > {35'd0, 61'h1000_0000_0000_0000}) ?
                   61'h1000_0000_0000_0000 : pix_m[60:0];
        pix_sc   = pix_d[47] ? (64'd0 - {3'd0, pix_c}) : {3'd0, pix_c};
        pix_s    = pix_sc + {{16{pix_pp[47]}}, pix_pp};
        pix_smag = pix_s[63] ? (64'd0 - pix_s) : pix_s;
        pix_res  = sat48(pix_s[63], {64'd0, pix_smag});
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = (i_req_type == REQ_TO_PIXEL && i_in_z == '0) ? S_OUT : S_DIV_X;
                end
            end
            S_DIV_X:  if (arith_rsp.done) n_state = S_DIV_Y;
            S_DIV_Y: begin
                if (arith_rsp.done) begin
                    if (k_on) n_state = S_MUL_P;
                    else      n_state = (r_req_type == REQ_TO_PIXEL) ? S_PIX_X : S_OUT;
                end
            end
            S_MUL_P:  if (arith_rsp.done) n_state = S_MUL_Q;
            S_MUL_Q:  if (arith_rsp.done) n_state = S_MUL_PP;
            S_MUL_PP: if (arith_rsp.done) n_state = S_MUL_QQ;
            S_MUL_QQ: if (arith_rsp.done) n_state = S_MUL_T;
            S_MUL_T: begin
                if (arith_rsp.done) begin
                    n_state = (r_req_type == REQ_TO_PIXEL) ? S_DIV_IX : S_MUL_UX;
                end
            end
            S_MUL_UX: if (arith_rsp.done) n_state = S_MUL_UY;
            S_MUL_UY: if (arith_rsp.done) n_state = S_OUT;
            S_DIV_IX: if (arith_rsp.done) n_state = S_DIV_IY;
            S_DIV_IY: if (arith_rsp.done) n_state = S_CHECK;
            S_CHECK:  n_state = (match || r_iter == ITER_LAST) ? S_PIX_X : S_MUL_P;
            S_PIX_X:  if (arith_rsp.done) n_state = S_PIX_Y;
            S_PIX_Y:  if (arith_rsp.done) n_state = S_OUT;
            S_OUT:    if (!i_out_stall) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // operands for the shared unit
    always_comb begin
        arith_req.start = op_state && !r_launched;
        arith_req.op    = OP_MUL;
        arith_req.a     = '0;
        arith_req.b     = '0;
        unique case (r_state)
            S_DIV_X: begin
                arith_req.op = OP_DIV;
                arith_req.a  = {47'd0, r_nx, 32'd0};
                arith_req.b  = {80'd0, r_den};
            end
            S_DIV_Y: begin
                arith_req.op = OP_DIV;
                arith_req.a  = {47'd0, r_ny, 32'd0};
                arith_req.b  = {80'd0, r_den};
            end
            S_MUL_P, S_PIX_X: begin
                arith_req.a = {80'd0, mag48(r_rx)};
                arith_req.b = {80'd0, r_focal};
            end
            S_MUL_Q, S_PIX_Y: begin
                arith_req.a = {80'd0, mag48(r_ry)};
                arith_req.b = {80'd0, r_focal};
            end
            S_MUL_PP: begin
                arith_req.a = {65'd0, r_fx};
                arith_req.b = {65'd0, r_fx};
            end
            S_MUL_QQ: begin
                arith_req.a = {65'd0, r_fy};
                arith_req.b = {65'd0, r_fy};
            end
            S_MUL_T: begin
                arith_req.a = r_sum;
                arith_req.b = {64'd0, k_mag};
            end
            S_MUL_UX: begin
                arith_req.a = r_fac;
                arith_req.b = {80'd0, mag48(r_rx)};
            end
            S_MUL_UY: begin
                arith_req.a = r_fac;
                arith_req.b = {80'd0, mag48(r_ry)};
            end
            S_DIV_IX: begin
                arith_req.op = OP_DIV;
                arith_req.a  = {16'd0, mag48(r_ux), 64'd0};
                arith_req.b  = r_fac;
            end
            S_DIV_IY: begin
                arith_req.op = OP_DIV;
                arith_req.a  = {16'd0, mag48(r_uy), 64'd0};
                arith_req.b  = r_fac;
            end
            default: begin
                arith_req.op = OP_MUL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_launched <= 1'b0;
            r_focal    <= FOCAL_RESET;
            r_ppx      <= '0;
            r_ppy      <= '0;
            r_coeff    <= '0;
            r_sat      <= 1'b0;
            r_conv     <= 1'b1;
            r_zero     <= 1'b0;
            r_iter     <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FOCAL:  r_focal <= i_cfg_data[47:0];
                    CFG_PRIN_X: r_ppx   <= i_cfg_data[47:0];
                    CFG_PRIN_Y: r_ppy   <= i_cfg_data[47:0];
                    CFG_RADIAL: r_coeff <= i_cfg_data;
                    default:    r_coeff <= r_coeff;
                endcase
            end

            if (in_xfer) begin
                r_req_type <= i_req_type;
                r_sat      <= 1'b0;
                r_conv     <= 1'b1;
                r_iter     <= '0;
                r_zero     <= (i_req_type == REQ_TO_PIXEL) && (i_in_z == '0);
                r_rx       <= '0;
                r_ry       <= '0;
                if (i_req_type == REQ_TO_PIXEL) begin
                    r_nx   <= {1'b0, mag48(i_in_x)};
                    r_ny   <= {1'b0, mag48(i_in_y)};
                    r_xneg <= i_in_x[47] ^ i_in_z[47];
                    r_yneg <= i_in_y[47] ^ i_in_z[47];
                    r_den  <= mag48(i_in_z);
                end else begin
                    r_nx   <= dx[48] ? (49'd0 - dx) : dx;
                    r_ny   <= dy[48] ? (49'd0 - dy) : dy;
                    r_xneg <= dx[48];
                    r_yneg <= dy[48];
                    r_den  <= r_focal;
                end
            end

            if (op_state && !r_launched) begin
                r_launched <= 1'b1;
            end else if (op_state && arith_rsp.done) begin
                r_launched <= 1'b0;
                case (r_state)
                    S_DIV_X: begin
                        r_ux  <= q_res.val;
                        r_rx  <= q_res.val;
                        r_sat <= r_sat | q_res.sat;
                    end
                    S_DIV_Y: begin
                        r_uy  <= q_res.val;
                        r_ry  <= q_res.val;
                        r_sat <= r_sat | q_res.sat;
                    end
                    S_MUL_P:  r_fx  <= arith_rsp.prod[94:32];
                    S_MUL_Q:  r_fy  <= arith_rsp.prod[94:32];
                    S_MUL_PP: r_sum <= arith_rsp.prod[127:0];
                    S_MUL_QQ: r_sum <= r_sum + arith_rsp.prod[127:0];
                    S_MUL_T: begin
                        r_fac  <= fac_val;
                        r_fneg <= fac_neg;
                    end
                    S_MUL_UX: begin
                        r_rx  <= m_res.val;
                        r_sat <= r_sat | m_res.sat;
                    end
                    S_MUL_UY: begin
                        r_ry  <= m_res.val;
                        r_sat <= r_sat | m_res.sat;
                    end
                    S_DIV_IX: begin
                        r_qx  <= q_res.val;
                        r_sat <= r_sat | q_res.sat;
                    end
                    S_DIV_IY: begin
                        r_qy  <= q_res.val;
                        r_sat <= r_sat | q_res.sat;
                    end
                    S_PIX_X: begin
                        r_rx  <= pix_res.val;
                        r_sat <= r_sat | pix_res.sat;
                    end
                    S_PIX_Y: begin
                        r_ry  <= pix_res.val;
                        r_sat <= r_sat | pix_res.sat;
                    end
                    default: ;
                endcase
            end

            // iterate not settled: take the new point, give up after the last pass
            if (r_state == S_CHECK && !match) begin
                r_rx   <= r_qx;
                r_ry   <= r_qy;
                r_iter <= r_iter + 1'b1;
                if (r_iter == ITER_LAST) begin
                    r_conv <= 1'b0;
                end
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_x     = r_rx;
    assign o_out_y     = r_ry;
    assign o_status    = r_zero ? ST_ZERO_Z : (r_sat ? ST_SAT : (r_conv ? ST_OK : ST_NO_CONV));

endmodule

// ===== design/prdp_arith.sv =====
module prdp_arith
    import prdp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_arith_req i_req,
    output t_arith_rsp o_rsp
);

    logic         r_busy;
    logic         r_done;
    t_arith_op    r_op;
    logic [191:0] r_acc;
    logic [191:0] r_mcand;
    logic [63:0]  r_mplier;
    logic [127:0] r_num;
    logic [127:0] r_den;
    logic [128:0] r_rem;
    logic [127:0] r_quo;
    logic [6:0]   r_cnt;

    logic [128:0] rem_sh;
    logic [128:0] rem_diff;
    logic         rem_ge;

    assign rem_sh   = {r_rem[127:0], r_num[127]};
    assign rem_ge   = (rem_sh >= {1'b0, r_den});
    assign rem_diff = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_op <= i_req.op;
                if (i_req.op == OP_MUL) begin
                    r_acc    <= '0;
                    r_mcand  <= {64'd0, i_req.a};
                    r_mplier <= i_req.b[63:0];
                    r_busy   <= 1'b1;
                end else if (i_req.b == '0) begin
                    // divide by zero gives an all-ones quotient
                    r_quo  <= '1;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_num  <= i_req.a;
                    r_den  <= i_req.b;
                    r_rem  <= '0;
                    r_cnt  <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_op == OP_MUL) begin
                    // stop once no multiplier bits remain
                    if (r_mplier == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        if (r_mplier[0]) begin
                            r_acc <= r_acc + r_mcand;
                        end
                        r_mcand  <= {r_mcand[190:0], 1'b0};
                        r_mplier <= {1'b0, r_mplier[63:1]};
                    end
                end else begin
                    r_rem <= rem_ge ? rem_diff : rem_sh;
                    r_quo <= {r_quo[126:0], rem_ge};
                    r_num <= {r_num[126:0], 1'b0};
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd127) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;
    assign o_rsp.quot = r_quo;

endmodule

// ===== design/prdp_checker.sv =====
module prdp_checker
    import prdp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [47:0] o_out_x,
    input logic signed [47:0] o_out_y,
    input logic [1:0]         o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out_x) && $stable(o_out_y) && $stable(o_status)))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result is pending");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> !o_out_valid)
        else $error("result repeated after transfer");

    a_zero_z_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_ZERO_Z) |-> (o_out_x == '0 && o_out_y == '0))
        else $error("zero z result not cleared");

endmodule

bind pinhole_radial_distortion_projection prdp_checker u_prdp_checker (.*);

// ===== dv/testbench.sv =====
module testbench
    import prdp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NO_PROGRESS_LIMIT = 400000;
    localparam logic [47:0] S48_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] S48_MIN = 48'h8000_0000_0000;
    localparam logic [47:0] ONE_Q32 = 48'h0001_0000_0000;

    typedef struct {
        logic [47:0] x;
        logic [47:0] y;
        logic [1:0]  status;
    } t_point;

    typedef struct {
        logic        req;
        logic [47:0] x;
        logic [47:0] y;
        logic [47:0] z;
        bit          typed;
        t_point      want;
    } t_request;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = CFG_FOCAL;
    logic [63:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_req_type = REQ_TO_RAY;
    logic signed [47:0] i_in_x = '0;
    logic signed [47:0] i_in_y = '0;
    logic signed [47:0] i_in_z = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [47:0] o_out_x;
    logic signed [47:0] o_out_y;
    logic [1:0]         o_status;

    pinhole_radial_distortion_projection i_dut (.*);

    always #4 i_clk = ~i_clk;

    // camera settings as the block should hold them
    logic [47:0] cam_focal;
    logic [47:0] cam_px;
    logic [47:0] cam_py;
    logic [63:0] cam_k;

    t_point   projections_due[$];
    t_request cur_req;
    int       errors = 0;
    int       idle_pct = 0;
    int       stall_pct = 0;
    int       quiet_cycles = 0;

    function automatic longint sx48(logic [47:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic logic [63:0] mag(longint a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    function automatic logic [127:0] mul_shift(logic [127:0] a, logic [63:0] b, int sh);
        logic [191:0] full;
        full = ({64'd0, a} * {128'd0, b}) >> sh;
        return (full[191:128] != 0) ? {128{1'b1}} : full[127:0];
    endfunction

    function automatic logic [127:0] div_q(logic [127:0] n, logic [127:0] d);
        return (d == 0) ? {128{1'b1}} : n / d;
    endfunction

    function automatic logic [127:0] add_clip(logic [127:0] a, logic [127:0] b);
        logic [128:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[128] ? {128{1'b1}} : s[127:0];
    endfunction

    function automatic longint clip48(logic neg, logic [127:0] m, inout bit sat);
        logic [127:0] lim;
        lim = neg ? 128'(S48_MIN) : 128'(S48_MAX);
        if (m > lim) begin
            m   = lim;
            sat = 1'b1;
        end
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    // 1 + k*(f*d)^2 in Q.64, magnitude with sign in neg
    function automatic logic [127:0] dist_factor(longint dx, longint dy, output logic neg);
        logic [63:0]  p;
        logic [63:0]  q;
        logic [127:0] t;
        logic [127:0] one;
        logic [63:0]  kmag;
        p    = 64'(mul_shift(128'(mag(dx)), 64'(cam_focal), 32));
        q    = 64'(mul_shift(128'(mag(dy)), 64'(cam_focal), 32));
        kmag = cam_k[63] ? -cam_k : cam_k;
        t    = mul_shift(add_clip(128'(p) * 128'(p), 128'(q) * 128'(q)), kmag, 56);
        one  = 128'd1 << 64;
        neg  = 1'b0;
        if (!cam_k[63])
            return add_clip(one, t);
        if (one >= t)
            return one - t;
        neg = 1'b1;
        return t - one;
    endfunction

    function automatic longint to_pixel(longint d, logic [47:0] pp, inout bit sat);
        logic [127:0] m;
        logic [63:0]  c;
        longint       s;
        m = mul_shift(128'(mag(d)), 64'(cam_focal), 32);
        c = (m > (128'd1 << 60)) ? (64'd1 << 60) : m[63:0];
        s = (d < 0 ? -longint'(c) : longint'(c)) + sx48(pp);
        return clip48(s < 0, 128'(mag(s)), sat);
    endfunction

    function automatic t_point project(t_request r);
        t_point       o;
        bit           sat;
        bit           conv;
        logic         fneg;
        logic [127:0] fac;
        longint       x, y, z, dx, dy, rx, ry, ux, uy, qx, qy;
        sat  = 1'b0;
        conv = 1'b1;
        x = sx48(r.x);
        y = sx48(r.y);
        z = sx48(r.z);
        if (r.req == REQ_TO_RAY) begin
            dx = x - sx48(cam_px);
            dy = y - sx48(cam_py);
            rx = clip48(dx < 0, div_q(128'(mag(dx)) << 32, 128'(cam_focal)), sat);
            ry = clip48(dy < 0, div_q(128'(mag(dy)) << 32, 128'(cam_focal)), sat);
            if (cam_k != 0) begin
                fac = dist_factor(rx, ry, fneg);
                rx  = clip48((rx < 0) != fneg, mul_shift(fac, mag(rx), 64), sat);
                ry  = clip48((ry < 0) != fneg, mul_shift(fac, mag(ry), 64), sat);
            end
        end else begin
            if (z == 0) begin
                o.x      = '0;
                o.y      = '0;
                o.status = ST_ZERO_Z;
                return o;
            end
            ux = clip48((x < 0) != (z < 0), div_q(128'(mag(x)) << 32, 128'(mag(z))), sat);
            uy = clip48((y < 0) != (z < 0), div_q(128'(mag(y)) << 32, 128'(mag(z))), sat);
            rx = ux;
            ry = uy;
            if (cam_k != 0) begin
                conv = 1'b0;
                for (int i = 0; i < 100; i++) begin
                    fac = dist_factor(rx, ry, fneg);
                    qx  = clip48((ux < 0) != fneg, div_q(128'(mag(ux)) << 64, fac), sat);
                    qy  = clip48((uy < 0) != fneg, div_q(128'(mag(uy)) << 64, fac), sat);
                    if (qx == rx && qy == ry) begin
                        conv = 1'b1;
                        break;
                    end
                    rx = qx;
                    ry = qy;
                end
            end
            rx = to_pixel(rx, cam_px, sat);
            ry = to_pixel(ry, cam_py, sat);
        end
        o.x      = rx[47:0];
        o.y      = ry[47:0];
        o.status = sat ? ST_SAT : (conv ? ST_OK : ST_NO_CONV);
        return o;
    endfunction

    // input transfers: queue what the block should answer
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (cur_req.typed)
                projections_due.push_back(cur_req.want);
            else
                projections_due.push_back(project(cur_req));
        end
    end

    // output transfers: compare with oldest expectation
    always @(posedge i_clk) begin
        t_point w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (projections_due.size() == 0) begin
                $error("result with nothing expected: x=%h y=%h status=%0d",
                       o_out_x, o_out_y, o_status);
                errors++;
            end else begin
                w = projections_due.pop_front();
                if (o_out_x !== w.x) begin
                    $error("out_x expected %h actual %h", w.x, o_out_x);
                    errors++;
                end
                if (o_out_y !== w.y) begin
                    $error("out_y expected %h actual %h", w.y, o_out_y);
                    errors++;
                end
                if (o_status !== w.status) begin
                    $error("status expected %0d actual %0d", w.status, o_status);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= NO_PROGRESS_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_FOCAL:  cam_focal = data[47:0];
            CFG_PRIN_X: cam_px    = data[47:0];
            CFG_PRIN_Y: cam_py    = data[47:0];
            CFG_RADIAL: cam_k     = data;
        endcase
    endtask

    task automatic send(t_request r);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct)
            @(negedge i_clk);
        cur_req    = r;
        i_req_type = r.req;
        i_in_x     = r.x;
        i_in_y     = r.y;
        i_in_z     = r.z;
        i_in_valid = 1'b1;
        do
            @(posedge i_clk);
        while (o_in_stall);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic logic [47:0] rand_coord(int span);
        logic [47:0] v;
        v = {16'd0, $urandom()} + (48'($urandom_range(span)) << 32);
        return $urandom_range(1) ? -v : v;
    endfunction

    function automatic t_request rand_request();
        t_request r;
        r.req   = 1'($urandom_range(1));
        r.typed = 1'b0;
        if ($urandom_range(99) < 75) begin
            r.x = rand_coord(r.req == REQ_TO_RAY ? 1000 : 2);
            r.y = rand_coord(r.req == REQ_TO_RAY ? 1000 : 2);
            r.z = ($urandom_range(19) == 0) ? 48'd0 : 48'(ONE_Q32 + rand_coord(0));
        end else begin
            r.x = rand48();
            r.y = rand48();
            r.z = ($urandom_range(9) == 0) ? 48'd0 : rand48();
        end
        return r;
    endfunction

    task automatic wait_drained();
        while (projections_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic t_request row(logic req, logic [47:0] x, logic [47:0] y,
                                     logic [47:0] z, bit typed, logic [47:0] ox,
                                     logic [47:0] oy, logic [1:0] st);
        t_request r;
        r.req         = req;
        r.x           = x;
        r.y           = y;
        r.z           = z;
        r.typed       = typed;
        r.want.x      = ox;
        r.want.y      = oy;
        r.want.status = st;
        return r;
    endfunction

    t_request directed[$];

    initial begin
        cam_focal = FOCAL_RESET;
        cam_px    = '0;
        cam_py    = '0;
        cam_k     = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // defaults: unit focal length, no offset, no distortion
        directed = '{
            row(REQ_TO_RAY, 0, 0, 0, 1, 0, 0, ST_OK),
            row(REQ_TO_RAY, S48_MAX, S48_MIN, S48_MAX, 1, S48_MAX, S48_MIN, ST_OK),
            row(REQ_TO_RAY, S48_MIN, S48_MAX, S48_MIN, 1, S48_MIN, S48_MAX, ST_OK),
            row(REQ_TO_RAY, ONE_Q32, -ONE_Q32, 1, 1, ONE_Q32, -ONE_Q32, ST_OK),
            row(REQ_TO_PIXEL, ONE_Q32, S48_MAX, 0, 1, 0, 0, ST_ZERO_Z),
            row(REQ_TO_PIXEL, S48_MIN, S48_MAX, 0, 1, 0, 0, ST_ZERO_Z),
            row(REQ_TO_PIXEL, ONE_Q32, -3 * ONE_Q32, ONE_Q32, 1,
                ONE_Q32, -3 * ONE_Q32, ST_OK),
            row(REQ_TO_PIXEL, S48_MAX, S48_MIN, 1, 0, 0, 0, ST_OK),
            row(REQ_TO_PIXEL, S48_MAX, S48_MIN, -1, 0, 0, 0, ST_OK),
            row(REQ_TO_PIXEL, S48_MIN, S48_MIN, S48_MIN, 0, 0, 0, ST_OK),
            row(REQ_TO_PIXEL, S48_MAX, S48_MAX, S48_MAX, 0, 0, 0, ST_OK),
            row(REQ_TO_PIXEL, S48_MIN, S48_MAX, S48_MAX, 0, 0, 0, ST_OK),
            row(REQ_TO_PIXEL, 7 * ONE_Q32, 5, -2 * ONE_Q32, 0, 0, 0, ST_OK),
            row(REQ_TO_PIXEL, 0, 0, S48_MIN, 0, 0, 0, ST_OK),
            row(REQ_TO_RAY, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 0, 0, 0, 0, ST_OK)
        };
        foreach (directed[i])
            send(directed[i]);

        for (int ph = 0; ph < 7; ph++) begin
            int n;
            wait_drained();
            case (ph)
                0: n = 300;
                1: begin
                    write_reg(CFG_FOCAL, 64'd500 << 32);
                    write_reg(CFG_PRIN_X, 64'd320 << 32);
                    write_reg(CFG_PRIN_Y, 64'd240 << 32);
                    n = 300;
                end
                2: begin
                    write_reg(CFG_RADIAL, 64'd7205759403);
                    n = 230;
                end
                3: begin
                    write_reg(CFG_RADIAL, -64'd7205759403);
                    n = 230;
                end
                4: begin
                    write_reg(CFG_FOCAL, 64'd1);
                    write_reg(CFG_PRIN_X, 64'(signed'(S48_MIN)));
                    write_reg(CFG_PRIN_Y, 64'(S48_MAX));
                    write_reg(CFG_RADIAL, 64'h7FFF_FFFF_FFFF_FFFF);
                    n = 12;
                end
                5: begin
                    write_reg(CFG_FOCAL, 64'(48'hFFFF_FFFF_FFFF));
                    write_reg(CFG_PRIN_X, 64'd0);
                    write_reg(CFG_PRIN_Y, 64'd0);
                    write_reg(CFG_RADIAL, 64'h8000_0000_0000_0000);
                    n = 12;
                end
                default: begin
                    // strong barrel term so the iteration may not settle
                    write_reg(CFG_FOCAL, 64'd800 << 32);
                    write_reg(CFG_RADIAL, 64'd1 << 48);
                    n = 150;
                end
            endcase
            for (int i = 0; i < n; i++) begin
                case ((i / 40) % 4)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 81; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 81; end
                    default: begin idle_pct = 10; stall_pct = 10; end
                endcase
                send(rand_request());
            end
        end

        wait_drained();
        repeat (100) @(negedge i_clk);
        if (errors == 0 && projections_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
